// File: rtl/pdc_pkg.sv
// Shared types and constants for the polyline direction color block.
package pdc_pkg;

  // Default coordinate width (signed Q15.8)
  localparam int COORD_BITS_DEF = 24;

  // Color channel width and fixed colors
  localparam int COLOR_W = 8;
  localparam logic [COLOR_W-1:0] GREY_LEVEL = 8'd128;

  // Configuration port widths
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 8;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_COLOR_MODE  = 8'd0,
    CFG_SOLID_RED   = 8'd1,
    CFG_SOLID_GREEN = 8'd2,
    CFG_SOLID_BLUE  = 8'd3
  } pdc_cfg_idx_e;

  // Reset values of the configuration registers
  localparam logic                  COLOR_MODE_RST  = 1'b0;
  localparam logic [COLOR_W-1:0]    SOLID_RED_RST   = 8'd255;
  localparam logic [COLOR_W-1:0]    SOLID_GREEN_RST = 8'd0;
  localparam logic [COLOR_W-1:0]    SOLID_BLUE_RST  = 8'd0;

  // Track position: points seen since the start of the current track
  localparam logic [1:0] SEEN_NONE = 2'd0;
  localparam logic [1:0] SEEN_ONE  = 2'd1;
  localparam logic [1:0] SEEN_MANY = 2'd2;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_START,
    ST_DIFF,
    ST_SQUARE,
    ST_ROOT,
    ST_DIV_INIT,
    ST_DIV_STEP,
    ST_EMIT
  } pdc_state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_in;     // capture the incoming point
    logic shift;       // older <= newer, newer <= point
    logic diff;        // form |head - tail| and clear the arithmetic
    logic tail_older;  // tail is the older point, else the newer one
    logic square;      // one square-and-accumulate step
    logic root_step;   // one square root iteration
    logic div_init;    // load dividend and divisor for the current channel
    logic div_step;    // one quotient bit
    logic load_out;    // write the output register
    logic single;      // result is the grey single-point color
    logic last;        // result belongs to the track's final point
  } pdc_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic solid;       // solid color mode is selected
    logic sq_last;     // final accumulate step
    logic root_last;   // final square root iteration
    logic div_last;    // final quotient bit
    logic chan_last;   // blue channel under division
    logic out_free;    // output register can take a result
  } pdc_status_t;

endpackage

// File: rtl/polyline_direction_color.sv
// Top level of the polyline direction color block.
//
// Points of polyline tracks enter on the input channel (in_valid_i / in_stall_o),
// one request per point, with track_end_i set on a track's last point. Colors
// leave on the output channel (out_valid_o / out_stall_i), one per point, in
// point order, lagging one point: the last point of a track gives two colors.
// A track of one point gives a single grey color.
// Registers are written on the cfg channel (index 0 mode, 1..3 solid RGB);
// cfg_ready_o is always high and writes belong to idle periods.
// A direction color is set by the one-bit-per-cycle square root and the
// shared 8-step divider run once per channel. A first point, a single-point
// track or a solid-mode color skips the square root and the divider.
// The next point is taken while a finished color waits in the output register.
// A stalled output holds its color; the block then waits before loading the
// next one. Reset empties the output, clears the point history and starts a
// new track; the solid color resets to red in direction mode.
module polyline_direction_color #(
  parameter int COORD_BITS = pdc_pkg::COORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [COORD_BITS-1:0]      coord_x_i,
  input  logic signed [COORD_BITS-1:0]      coord_y_i,
  input  logic signed [COORD_BITS-1:0]      coord_z_i,
  input  logic                              track_end_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [pdc_pkg::COLOR_W-1:0]       red_o,
  output logic [pdc_pkg::COLOR_W-1:0]       green_o,
  output logic [pdc_pkg::COLOR_W-1:0]       blue_o,
  output logic                              last_of_track_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [pdc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pdc_pkg::CFG_DATA_W-1:0]    cfg_data_i
);

  pdc_pkg::pdc_cmd_t    cmd;
  pdc_pkg::pdc_status_t status;

  assign cfg_ready_o = 1'b1;

  pdc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .track_end_i (track_end_i),
    .in_stall_o  (in_stall_o),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  pdc_dpath #(
    .COORD_BITS (COORD_BITS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .coord_x_i       (coord_x_i),
    .coord_y_i       (coord_y_i),
    .coord_z_i       (coord_z_i),
    .cfg_we_i        (cfg_valid_i && cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .out_stall_i     (out_stall_i),
    .out_valid_o     (out_valid_o),
    .red_o           (red_o),
    .green_o         (green_o),
    .blue_o          (blue_o),
    .last_of_track_o (last_of_track_o),
    .cmd_i           (cmd),
    .status_o        (status)
  );

endmodule

// File: rtl/pdc_ctrl.sv
// Sequencer for the polyline direction color block.
module pdc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                track_end_i,
  output logic                in_stall_o,
  input  pdc_pkg::pdc_status_t status_i,
  output pdc_pkg::pdc_cmd_t    cmd_o
);

  pdc_pkg::pdc_state_e state_q, state_d;
  logic [1:0] seen_q, seen_d;
  logic       end_q, end_d;
  logic       second_q, second_d;
  logic       single_q, single_d;
  logic       last_q, last_d;
  logic       tail_older_q, tail_older_d;

  // Hold state and track bookkeeping
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= pdc_pkg::ST_IDLE;
      seen_q       <= pdc_pkg::SEEN_NONE;
      end_q        <= 1'b0;
      second_q     <= 1'b0;
      single_q     <= 1'b0;
      last_q       <= 1'b0;
      tail_older_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      seen_q       <= seen_d;
      end_q        <= end_d;
      second_q     <= second_d;
      single_q     <= single_d;
      last_q       <= last_d;
      tail_older_q <= tail_older_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d      = state_q;
    seen_d       = seen_q;
    end_d        = end_q;
    second_d     = second_q;
    single_d     = single_q;
    last_d       = last_q;
    tail_older_d = tail_older_q;
    in_stall_o   = 1'b1;
    cmd_o            = '0;
    cmd_o.single     = single_q;
    cmd_o.last       = last_q;
    cmd_o.tail_older = tail_older_q;

    case (state_q)
      pdc_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          end_d         = track_end_i;
          state_d       = pdc_pkg::ST_START;
        end
      end

      // Pick the tangent for the first result of this point
      pdc_pkg::ST_START: begin
        second_d = 1'b0;
        if (seen_q == pdc_pkg::SEEN_NONE) begin
          if (end_q) begin
            single_d = 1'b1;
            last_d   = 1'b1;
            state_d  = pdc_pkg::ST_EMIT;
          end else begin
            cmd_o.shift = 1'b1;
            seen_d      = pdc_pkg::SEEN_ONE;
            state_d     = pdc_pkg::ST_IDLE;
          end
        end else begin
          single_d     = 1'b0;
          last_d       = 1'b0;
          tail_older_d = (seen_q != pdc_pkg::SEEN_ONE);
          state_d      = pdc_pkg::ST_DIFF;
        end
      end

      pdc_pkg::ST_DIFF: begin
        cmd_o.diff = 1'b1;
        state_d    = status_i.solid ? pdc_pkg::ST_EMIT : pdc_pkg::ST_SQUARE;
      end

      pdc_pkg::ST_SQUARE: begin
        cmd_o.square = 1'b1;
        if (status_i.sq_last) begin
          state_d = pdc_pkg::ST_ROOT;
        end
      end

      pdc_pkg::ST_ROOT: begin
        cmd_o.root_step = 1'b1;
        if (status_i.root_last) begin
          state_d = pdc_pkg::ST_DIV_INIT;
        end
      end

      pdc_pkg::ST_DIV_INIT: begin
        cmd_o.div_init = 1'b1;
        state_d        = pdc_pkg::ST_DIV_STEP;
      end

      pdc_pkg::ST_DIV_STEP: begin
        cmd_o.div_step = 1'b1;
        if (status_i.div_last) begin
          state_d = status_i.chan_last ? pdc_pkg::ST_EMIT : pdc_pkg::ST_DIV_INIT;
        end
      end

      // Hand the result over, then run the backward tangent or finish
      pdc_pkg::ST_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.load_out = 1'b1;
          if (single_q) begin
            seen_d  = pdc_pkg::SEEN_NONE;
            state_d = pdc_pkg::ST_IDLE;
          end else if (end_q && !second_q) begin
            second_d     = 1'b1;
            last_d       = 1'b1;
            tail_older_d = 1'b0;
            state_d      = pdc_pkg::ST_DIFF;
          end else if (end_q) begin
            seen_d  = pdc_pkg::SEEN_NONE;
            state_d = pdc_pkg::ST_IDLE;
          end else begin
            cmd_o.shift = 1'b1;
            seen_d      = pdc_pkg::SEEN_MANY;
            state_d     = pdc_pkg::ST_IDLE;
          end
        end
      end

      default: begin
        state_d = pdc_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/pdc_dpath.sv
// Datapath: point history, tangent length, channel division and output register.
module pdc_dpath #(
  parameter int COORD_BITS = pdc_pkg::COORD_BITS_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic signed [COORD_BITS-1:0]      coord_x_i,
  input  logic signed [COORD_BITS-1:0]      coord_y_i,
  input  logic signed [COORD_BITS-1:0]      coord_z_i,
  input  logic                              cfg_we_i,
  input  logic [pdc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [pdc_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              out_stall_i,
  output logic                              out_valid_o,
  output logic [pdc_pkg::COLOR_W-1:0]       red_o,
  output logic [pdc_pkg::COLOR_W-1:0]       green_o,
  output logic [pdc_pkg::COLOR_W-1:0]       blue_o,
  output logic                              last_of_track_o,
  input  pdc_pkg::pdc_cmd_t                 cmd_i,
  output pdc_pkg::pdc_status_t              status_o
);

  localparam int AW = COORD_BITS;         // absolute difference
  localparam int SW = 2 * COORD_BITS + 2; // sum of squares
  localparam int RW = COORD_BITS + 1;     // square root
  localparam int DW = COORD_BITS + 8;     // dividend and divisor
  localparam int CW = pdc_pkg::COLOR_W;

  // Configuration registers
  logic          color_mode_q;
  logic [CW-1:0] solid_red_q, solid_green_q, solid_blue_q;

  // Point history
  logic [AW-1:0] p_q     [3];
  logic [AW-1:0] newer_q [3];
  logic [AW-1:0] older_q [3];

  // Arithmetic state
  logic [AW-1:0]   a_q [3];
  logic [2*AW-1:0] prod_q;
  logic [SW-1:0]   acc_q;
  logic [SW-1:0]   root_q;
  logic [SW-1:0]   bit_q;
  logic [1:0]      sq_cnt_q;
  logic [DW-1:0]   rem_q, dvs_q;
  logic [CW-1:0]   quo_q;
  logic [2:0]      div_cnt_q;
  logic [1:0]      chan_q;
  logic [CW-1:0]   ch_q [3];

  // Output register
  logic          out_valid_q;
  logic [CW-1:0] red_q, green_q, blue_q;
  logic          last_q;

  // Combinational helpers
  logic [AW-1:0]        tail_pt [3];
  logic signed [AW:0]   dif     [3];
  logic [AW-1:0]        abs_d   [3];
  logic [AW-1:0]        a_sq;
  logic [2*AW-1:0]      prod_d;
  logic [SW-1:0]        trial;
  logic                 root_ge;
  logic [AW-1:0]        a_div;
  logic                 div_ge;
  logic [CW-1:0]        quo_d;
  logic                 zero_len;
  logic                 out_free;
  logic [CW-1:0]        red_d, green_d, blue_d;

  // Write configuration registers; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      color_mode_q  <= pdc_pkg::COLOR_MODE_RST;
      solid_red_q   <= pdc_pkg::SOLID_RED_RST;
      solid_green_q <= pdc_pkg::SOLID_GREEN_RST;
      solid_blue_q  <= pdc_pkg::SOLID_BLUE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        pdc_pkg::CFG_COLOR_MODE:  color_mode_q  <= cfg_data_i[0];
        pdc_pkg::CFG_SOLID_RED:   solid_red_q   <= cfg_data_i[CW-1:0];
        pdc_pkg::CFG_SOLID_GREEN: solid_green_q <= cfg_data_i[CW-1:0];
        pdc_pkg::CFG_SOLID_BLUE:  solid_blue_q  <= cfg_data_i[CW-1:0];
        default: ;
      endcase
    end
  end

  // Capture the point and advance the history
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) begin
        newer_q[k] <= '0;
        older_q[k] <= '0;
      end
    end else if (cmd_i.shift) begin
      for (int k = 0; k < 3; k++) begin
        older_q[k] <= newer_q[k];
        newer_q[k] <= p_q[k];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      p_q[0] <= coord_x_i;
      p_q[1] <= coord_y_i;
      p_q[2] <= coord_z_i;
    end
  end

  // Per-axis absolute difference between head and tail
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      tail_pt[k] = cmd_i.tail_older ? older_q[k] : newer_q[k];
      dif[k]     = $signed({p_q[k][AW-1], p_q[k]}) - $signed({tail_pt[k][AW-1], tail_pt[k]});
      abs_d[k]   = dif[k][AW] ? AW'(-dif[k]) : dif[k][AW-1:0];
    end
  end

  // Operand selects for the shared multiplier and divider
  always_comb begin
    case (sq_cnt_q)
      2'd1:    a_sq = a_q[1];
      2'd2:    a_sq = a_q[2];
      default: a_sq = a_q[0];
    endcase
    case (chan_q)
      2'd1:    a_div = a_q[1];
      2'd2:    a_div = a_q[2];
      default: a_div = a_q[0];
    endcase
    prod_d  = a_sq * a_sq;
    trial   = root_q + bit_q;
    root_ge = (acc_q >= trial);
    div_ge  = (rem_q >= dvs_q);
    quo_d   = {quo_q[CW-2:0], div_ge};
  end

  // Squares, integer square root and restoring division
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sq_cnt_q  <= '0;
      div_cnt_q <= '0;
      chan_q    <= '0;
    end else begin
      if (cmd_i.diff) begin
        sq_cnt_q <= '0;
        chan_q   <= '0;
      end else if (cmd_i.square) begin
        sq_cnt_q <= sq_cnt_q + 2'd1;
      end
      if (cmd_i.div_init) begin
        div_cnt_q <= '0;
      end else if (cmd_i.div_step) begin
        div_cnt_q <= div_cnt_q + 3'd1;
        if (div_cnt_q == 3'd7) begin
          chan_q <= chan_q + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.diff) begin
      for (int k = 0; k < 3; k++) begin
        a_q[k] <= abs_d[k];
      end
      acc_q  <= '0;
      root_q <= '0;
      bit_q  <= {2'b01, {(SW-2){1'b0}}};
    end
    if (cmd_i.square) begin
      prod_q <= prod_d;
      if (sq_cnt_q != 2'd0) begin
        acc_q <= acc_q + SW'(prod_q);
      end
    end
    if (cmd_i.root_step) begin
      if (root_ge) begin
        acc_q  <= acc_q - trial;
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
    if (cmd_i.div_init) begin
      rem_q <= {a_div, 8'd0} - DW'(a_div);
      dvs_q <= {root_q[RW-1:0], 7'd0};
      quo_q <= '0;
    end
    if (cmd_i.div_step) begin
      if (div_ge) begin
        rem_q <= rem_q - dvs_q;
      end
      dvs_q <= dvs_q >> 1;
      quo_q <= quo_d;
      if (div_cnt_q == 3'd7) begin
        for (int k = 0; k < 3; k++) begin
          if (chan_q == 2'(k)) begin
            ch_q[k] <= quo_d;
          end
        end
      end
    end
  end

  // Choose the color of the result
  assign zero_len = (root_q == '0);
  always_comb begin
    if (color_mode_q) begin
      red_d   = solid_red_q;
      green_d = solid_green_q;
      blue_d  = solid_blue_q;
    end else if (cmd_i.single) begin
      red_d   = pdc_pkg::GREY_LEVEL;
      green_d = pdc_pkg::GREY_LEVEL;
      blue_d  = pdc_pkg::GREY_LEVEL;
    end else if (zero_len) begin
      red_d   = '0;
      green_d = '0;
      blue_d  = '0;
    end else begin
      red_d   = ch_q[0];
      green_d = ch_q[1];
      blue_d  = ch_q[2];
    end
  end

  // Output register: load when empty or being drained
  assign out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
      last_q  <= cmd_i.last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign red_o           = red_q;
  assign green_o         = green_q;
  assign blue_o          = blue_q;
  assign last_of_track_o = last_q;

  // Report progress to the controller
  always_comb begin
    status_o           = '0;
    status_o.solid     = color_mode_q;
    status_o.sq_last   = (sq_cnt_q == 2'd3);
    status_o.root_last = bit_q[0];
    status_o.div_last  = (div_cnt_q == 3'd7);
    status_o.chan_last = (chan_q == 2'd2);
    status_o.out_free  = out_free;
  end

endmodule

// File: rtl/pdc_checker.sv
// Port-level checks for the polyline direction color block, bound to the top level.
module pdc_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic [pdc_pkg::COLOR_W-1:0] red_o,
  input logic [pdc_pkg::COLOR_W-1:0] green_o,
  input logic [pdc_pkg::COLOR_W-1:0] blue_o,
  input logic                        last_of_track_o,
  input logic                        cfg_ready_o
);

  // An accepted point keeps the block busy for at least the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken again right after a request");

  // A new color only appears while a point is being worked on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("color produced while the block was idle");

  // A stalled color stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("stalled color dropped");

  // A stalled color holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      $stable(red_o) && $stable(green_o) && $stable(blue_o) && $stable(last_of_track_o))
    else $error("stalled color changed");

  // Register writes are always taken
  assert property (@(posedge clk_i) disable iff (!rst_ni) cfg_ready_o)
    else $error("configuration port not ready");

endmodule

bind polyline_direction_color pdc_checker u_pdc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .red_o           (red_o),
  .green_o         (green_o),
  .blue_o          (blue_o),
  .last_of_track_o (last_of_track_o),
  .cfg_ready_o     (cfg_ready_o)
);

// File: bench/pdc_color_checker.sv
// Checker for polyline_direction_color: predicts each point color and compares it.
`timescale 1ns / 100ps
module pdc_color_checker #(
  parameter int COORD_BITS = pdc_pkg::COORD_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  input  logic                           in_stall_i,
  input  logic signed [COORD_BITS-1:0]   coord_x_i,
  input  logic signed [COORD_BITS-1:0]   coord_y_i,
  input  logic signed [COORD_BITS-1:0]   coord_z_i,
  input  logic                           track_end_i,
  input  logic                           out_valid_i,
  input  logic                           out_stall_i,
  input  logic [pdc_pkg::COLOR_W-1:0]    red_i,
  input  logic [pdc_pkg::COLOR_W-1:0]    green_i,
  input  logic [pdc_pkg::COLOR_W-1:0]    blue_i,
  input  logic                           last_of_track_i,
  input  logic                           cfg_valid_i,
  input  logic                           cfg_ready_i,
  input  logic [pdc_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pdc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                             mismatch_count_o,
  output int                             due_count_o
);

  typedef logic signed [COORD_BITS-1:0] coord_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } point_t;

  typedef struct packed {
    logic [pdc_pkg::COLOR_W-1:0] red;
    logic [pdc_pkg::COLOR_W-1:0] green;
    logic [pdc_pkg::COLOR_W-1:0] blue;
    logic                        last;
  } color_t;

  localparam longint unsigned FULL_SCALE   = 255;
  localparam int              REPORT_LIMIT = 10;

  // Register copies and track history
  logic                        mode_solid;
  logic [pdc_pkg::COLOR_W-1:0] solid_red;
  logic [pdc_pkg::COLOR_W-1:0] solid_green;
  logic [pdc_pkg::COLOR_W-1:0] solid_blue;
  point_t                      older_pt;
  point_t                      newer_pt;
  logic [1:0]                  track_pos;

  color_t due_colors[$];
  color_t got;
  color_t want;
  point_t pt;
  int     mismatches = 0;

  // Floor of the square root, built one result bit at a time from the top
  function automatic longint unsigned floor_root(input longint unsigned n);
    longint unsigned root;
    longint unsigned trial;
    root = 0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= n) root = trial;
    end
    return root;
  endfunction

  // Magnitude of the difference along one axis
  function automatic longint unsigned axis_gap(input coord_t a, input coord_t b);
    longint d;
    d = longint'(a) - longint'(b);
    return (d < 0) ? -d : d;
  endfunction

  // Color of one point for the tangent head - tail
  function automatic color_t point_color(input point_t head, input point_t tail,
                                         input logic single, input logic last);
    color_t          c;
    longint unsigned mag[3];
    longint unsigned len;
    longint unsigned q;
    c.last = last;
    if (mode_solid) begin
      c.red   = solid_red;
      c.green = solid_green;
      c.blue  = solid_blue;
    end else if (single) begin
      c.red   = pdc_pkg::GREY_LEVEL;
      c.green = pdc_pkg::GREY_LEVEL;
      c.blue  = pdc_pkg::GREY_LEVEL;
    end else begin
      mag[0] = axis_gap(head.x, tail.x);
      mag[1] = axis_gap(head.y, tail.y);
      mag[2] = axis_gap(head.z, tail.z);
      len = floor_root(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
      // Zero length gives black; otherwise scale and clamp each channel
      for (int i = 0; i < 3; i++) begin
        q = (len == 0) ? 0 : (FULL_SCALE * mag[i]) / len;
        if (q > FULL_SCALE) q = FULL_SCALE;
        mag[i] = q;
      end
      c.red   = mag[0][pdc_pkg::COLOR_W-1:0];
      c.green = mag[1][pdc_pkg::COLOR_W-1:0];
      c.blue  = mag[2][pdc_pkg::COLOR_W-1:0];
    end
    return c;
  endfunction

  // Queue one predicted color behind the others
  task automatic add_due(input color_t c);
    due_colors.insert(due_colors.size(), c);
  endtask

  // Count a failure, print only the first few
  task automatic flag(input string msg);
    mismatches++;
    if (mismatches <= REPORT_LIMIT) $display("%0t pdc_color_checker: %s", $time, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_solid  = pdc_pkg::COLOR_MODE_RST;
      solid_red   = pdc_pkg::SOLID_RED_RST;
      solid_green = pdc_pkg::SOLID_GREEN_RST;
      solid_blue  = pdc_pkg::SOLID_BLUE_RST;
      older_pt    = '0;
      newer_pt    = '0;
      track_pos   = pdc_pkg::SEEN_NONE;
      due_colors.delete();
    end else begin
      // Compare a delivered color against the oldest prediction
      if (out_valid_i && !out_stall_i) begin
        got = {red_i, green_i, blue_i, last_of_track_i};
        if (due_colors.size() == 0) begin
          flag($sformatf("unexpected color %0d/%0d/%0d last %0b",
                         got.red, got.green, got.blue, got.last));
        end else begin
          want = due_colors.pop_front();
          if (got.red !== want.red || got.green !== want.green ||
              got.blue !== want.blue || got.last !== want.last) begin
            flag($sformatf("expected %0d/%0d/%0d last %0b, got %0d/%0d/%0d last %0b",
                           want.red, want.green, want.blue, want.last,
                           got.red, got.green, got.blue, got.last));
          end
        end
      end

      // Track register writes; unknown indexes are dropped
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          pdc_pkg::CFG_COLOR_MODE:  mode_solid  = cfg_data_i[0];
          pdc_pkg::CFG_SOLID_RED:   solid_red   = cfg_data_i;
          pdc_pkg::CFG_SOLID_GREEN: solid_green = cfg_data_i;
          pdc_pkg::CFG_SOLID_BLUE:  solid_blue  = cfg_data_i;
          default: ;
        endcase
      end

      // Predict the colors caused by an accepted point
      if (in_valid_i && !in_stall_i) begin
        pt = {coord_x_i, coord_y_i, coord_z_i};
        case (track_pos)
          pdc_pkg::SEEN_NONE: begin
            if (track_end_i) begin
              add_due(point_color(pt, pt, 1'b1, 1'b1));
            end else begin
              newer_pt  = pt;
              track_pos = pdc_pkg::SEEN_ONE;
            end
          end
          default: begin
            // Forward difference for the first point, central one further in
            if (track_pos == pdc_pkg::SEEN_ONE) begin
              add_due(point_color(pt, newer_pt, 1'b0, 1'b0));
            end else begin
              add_due(point_color(pt, older_pt, 1'b0, 1'b0));
            end
            // Backward difference for the last point closes the track
            if (track_end_i) begin
              add_due(point_color(pt, newer_pt, 1'b0, 1'b1));
              track_pos = pdc_pkg::SEEN_NONE;
            end else begin
              older_pt  = newer_pt;
              newer_pt  = pt;
              track_pos = pdc_pkg::SEEN_MANY;
            end
          end
        endcase
      end
    end
    due_count_o      = due_colors.size();
    mismatch_count_o = mismatches;
  end

endmodule

// File: bench/tb.sv
// Testbench top for polyline_direction_color: drives points and registers, gives the verdict.
`timescale 1ns / 100ps
module tb;

  localparam int     COORD_BITS    = pdc_pkg::COORD_BITS_DEF;
  localparam int     SETTLE_CYCLES = 2 * COORD_BITS + 100;
  localparam int     HOLD_CYCLES   = 600;
  localparam int     SEGMENTS      = 7;
  localparam int     SEG_POINTS    = 200;
  localparam int     IDLE_PCT      = 21;
  localparam longint LIMIT_NS      = 6_000_000;

  typedef logic signed [COORD_BITS-1:0]     coord_t;
  typedef logic [pdc_pkg::COLOR_W-1:0]      color_byte_t;
  typedef logic [pdc_pkg::CFG_IDX_W-1:0]    cfg_idx_t;
  typedef logic [pdc_pkg::CFG_DATA_W-1:0]   cfg_data_t;

  localparam coord_t COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
  localparam coord_t COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  coord_t      coord_x_i   = '0;
  coord_t      coord_y_i   = '0;
  coord_t      coord_z_i   = '0;
  logic        track_end_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  color_byte_t red_o;
  color_byte_t green_o;
  color_byte_t blue_o;
  logic        last_of_track_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  cfg_idx_t    cfg_index_i = '0;
  cfg_data_t   cfg_data_i  = '0;

  int   mismatch_count;
  int   due_count;
  int   hold_req  = 0;
  int   hold_done = 0;
  int   hold_left = 0;
  logic quiet     = 1'b0;

  polyline_direction_color #(
    .COORD_BITS(COORD_BITS)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .coord_x_i      (coord_x_i),
    .coord_y_i      (coord_y_i),
    .coord_z_i      (coord_z_i),
    .track_end_i    (track_end_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .red_o          (red_o),
    .green_o        (green_o),
    .blue_o         (blue_o),
    .last_of_track_o(last_of_track_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  pdc_color_checker #(
    .COORD_BITS(COORD_BITS)
  ) i_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .coord_x_i       (coord_x_i),
    .coord_y_i       (coord_y_i),
    .coord_z_i       (coord_z_i),
    .track_end_i     (track_end_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .red_i           (red_o),
    .green_i         (green_o),
    .blue_i          (blue_o),
    .last_of_track_i (last_of_track_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .mismatch_count_o(mismatch_count),
    .due_count_o     (due_count)
  );

  // Free-running clock
  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Stop a hung run
  initial begin
    #(LIMIT_NS);
    $display("tb: errors");
    $finish;
  end

  // Color receiver: random stalls, a long hold-off on request, none when quiet
  always @(posedge clk_i) begin
    if (hold_done != hold_req) begin
      hold_done   <= hold_req;
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (quiet) begin
      out_stall_i <= 1'b0;
    end else begin
      out_stall_i <= ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Offer one point and hold it until the block takes it
  task automatic send_point(input coord_t x, input coord_t y, input coord_t z,
                            input logic last);
    logic taken;
    if (!quiet && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 90)) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    coord_x_i   <= x;
    coord_y_i   <= y;
    coord_z_i   <= z;
    track_end_i <= last;
    do begin
      @(negedge clk_i);
      taken = !in_stall_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  // Write one register; the caller drops valid after the last write
  task automatic write_reg(input cfg_idx_t idx, input cfg_data_t data);
    logic taken;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do begin
      @(negedge clk_i);
      taken = cfg_ready_o;
      @(posedge clk_i);
    end while (!taken);
  endtask

  // Program mode and solid color, with a stray index and junk in the mode's upper bits
  task automatic apply_setting(input logic mode, input color_byte_t r,
                               input color_byte_t g, input color_byte_t b);
    cfg_data_t mode_word;
    mode_word    = cfg_data_t'($urandom);
    mode_word[0] = mode;
    write_reg(cfg_idx_t'($urandom_range((1 << pdc_pkg::CFG_IDX_W) - 1,
                                        pdc_pkg::CFG_SOLID_BLUE + 1)),
              cfg_data_t'($urandom));
    write_reg(pdc_pkg::CFG_COLOR_MODE, mode_word);
    write_reg(pdc_pkg::CFG_SOLID_RED, r);
    write_reg(pdc_pkg::CFG_SOLID_GREEN, g);
    write_reg(pdc_pkg::CFG_SOLID_BLUE, b);
    cfg_valid_i <= 1'b0;
  endtask

  // Drop valid, wait out every expected color, then let a silent first point finish
  task automatic settle();
    in_valid_i <= 1'b0;
    do @(negedge clk_i); while (due_count != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Next coordinate along a track: jump, small step, repeat or range limit
  function automatic coord_t next_coord(input coord_t prev);
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 25) return coord_t'($urandom);
    if (pick < 70) return coord_t'(prev + (int'($urandom_range(600)) - 300));
    if (pick < 84) return prev;
    if (pick < 92) return COORD_MIN;
    return COORD_MAX;
  endfunction

  task automatic send_track(input int len);
    coord_t x;
    coord_t y;
    coord_t z;
    x = coord_t'($urandom);
    y = coord_t'($urandom);
    z = coord_t'($urandom);
    for (int i = 0; i < len; i++) begin
      if (i > 0) begin
        x = next_coord(x);
        y = next_coord(y);
        z = next_coord(z);
      end
      send_point(x, y, z, i == len - 1);
    end
  endtask

  initial begin
    int          seg_points;
    int          len;
    int unsigned pick;

    // Reset once
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Single point: grey
    send_point(coord_t'(0), coord_t'(0), coord_t'(0), 1'b1);
    // Two points along x: forward and backward tangents
    send_point(coord_t'(0), coord_t'(0), coord_t'(0), 1'b0);
    send_point(coord_t'(256), coord_t'(0), coord_t'(0), 1'b1);
    // Opposite corners of the range
    send_point(COORD_MIN, COORD_MIN, COORD_MIN, 1'b0);
    send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b0);
    send_point(COORD_MIN, COORD_MAX, coord_t'(0), 1'b1);
    // Repeated point: zero-length tangents give black
    send_point(coord_t'(100), coord_t'(200), coord_t'(-300), 1'b0);
    send_point(coord_t'(100), coord_t'(200), coord_t'(-300), 1'b0);
    send_point(coord_t'(100), coord_t'(200), coord_t'(-300), 1'b1);
    // Out and back: the central difference at the turn is zero
    send_point(coord_t'(-5000), coord_t'(7), coord_t'(0), 1'b0);
    send_point(coord_t'(3000), coord_t'(-90), coord_t'(1), 1'b0);
    send_point(coord_t'(-5000), coord_t'(7), coord_t'(0), 1'b1);
    // Single point at the range limits
    send_point(COORD_MAX, COORD_MIN, coord_t'(0), 1'b1);
    // Full-range steps along one axis at a time
    send_point(COORD_MIN, coord_t'(0), coord_t'(0), 1'b0);
    send_point(COORD_MAX, coord_t'(0), coord_t'(0), 1'b0);
    send_point(COORD_MAX, coord_t'(0), COORD_MIN, 1'b1);
    settle();

    // Solid mode with extreme and grey channel values
    apply_setting(1'b1, '0, '1, pdc_pkg::GREY_LEVEL);
    send_point(coord_t'(10), coord_t'(20), coord_t'(30), 1'b0);
    send_point(coord_t'(-10), coord_t'(20), coord_t'(30), 1'b1);
    send_point(COORD_MAX, COORD_MAX, COORD_MAX, 1'b1);
    settle();

    // Random tracks, one register setting per segment
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      case (seg)
        2:       apply_setting(1'b1, color_byte_t'($urandom), color_byte_t'($urandom),
                               color_byte_t'($urandom));
        5:       apply_setting(1'b1, '1, '1, '1);
        6:       apply_setting(1'b0, '0, '0, '0);
        default: apply_setting(1'b0, color_byte_t'($urandom), color_byte_t'($urandom),
                               color_byte_t'($urandom));
      endcase
      // Hold off the receiver once so the block backs up
      if (seg == 0) hold_req <= hold_req + 1;
      quiet <= (seg == 1);
      seg_points = 0;
      while (seg_points < SEG_POINTS) begin
        pick = $urandom_range(99);
        if (pick < 10)      len = 1;
        else if (pick < 25) len = 2;
        else if (pick < 35) len = 3;
        else                len = $urandom_range(4, 12);
        send_track(len);
        seg_points += len;
      end
      settle();
    end

    if (mismatch_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/pdc_pkg.sv
rtl/pdc_ctrl.sv
rtl/pdc_dpath.sv
rtl/polyline_direction_color.sv
rtl/pdc_checker.sv
bench/pdc_color_checker.sv
bench/tb.sv
